// ----- hw/rtl/hbcd_pkg.sv -----
package hbcd_pkg;

    localparam int CountBitsDefault = 32;

    localparam int CfgWidth = 32;
    localparam int CfgIndexBits = 2;

    localparam logic [CfgIndexBits-1:0] REG_CHUNKED_MODE = 2'd0;
    localparam logic [CfgIndexBits-1:0] REG_CONTENT_LENGTH = 2'd1;
    localparam logic [CfgIndexBits-1:0] REG_MAX_BODY_SIZE = 2'd2;

    localparam logic [CfgWidth-1:0] MAX_BODY_SIZE_RESET = 32'd1048576;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_BAD   = 2'd1,
        ERR_LARGE = 2'd2
    } err_t;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;
    localparam logic [7:0] CHAR_LC_A = 8'h61;
    localparam logic [7:0] CHAR_LC_F = 8'h66;
    localparam logic [7:0] CHAR_UC_A = 8'h41;
    localparam logic [7:0] CHAR_UC_F = 8'h46;

    typedef struct packed {
        logic       ok;
        logic [3:0] digit;
    } hex_t;

    // Decode one ASCII hex digit; ok is low for any other character.
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t res;
        logic [7:0] diff;
        res = '0;
        diff = '0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            diff = c - CHAR_0;
            res.ok = 1'b1;
            res.digit = diff[3:0];
        end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
            diff = c - CHAR_LC_A + 8'd10;
            res.ok = 1'b1;
            res.digit = diff[3:0];
        end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
            diff = c - CHAR_UC_A + 8'd10;
            res.ok = 1'b1;
            res.digit = diff[3:0];
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/http_body_chunked_decoder.sv -----
// Request body decoder: one received byte in, one marked byte out.
// Input channel s_*: one body byte per transaction in s_tdata.
// Result channel m_*: the byte echoed in m_tdata, with body_valid, leftover,
// done_res and the sticky error code in m_tuser.
// Configuration: cfg_wr_en writes cfg_wdata to the register selected by
// cfg_index (0 chunked mode, 1 content length, 2 maximum body size); write
// only while no transaction is in flight.
// Each byte passes an input register, then the decode logic feeding the result
// register. Throughput: one byte per cycle while m_tready does not stall the
// result register.
// A stall on m_tready holds the result register; the input register then
// fills and s_tready drops, so one byte waits on each side.
// Reset (aresetn low, synchronous) empties both registers, returns the parser
// to the start of a size line with cleared counters and no error, and loads
// the register reset values (length mode, zero length, 1 MiB limit).
module http_body_chunked_decoder
    import hbcd_pkg::*;
#(
    parameter int COUNT_BITS = CountBitsDefault
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,    // [7:0] in_byte

    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata,    // [7:0] out_byte
    output logic [4:0]              m_tuser,    // [0] body_valid, [1] leftover,
                                                // [2] done_res, [4:3] error_code

    input  logic                    cfg_wr_en,
    input  logic [CfgIndexBits-1:0] cfg_index,
    input  logic [CfgWidth-1:0]     cfg_wdata
);

    localparam int CmpW = (COUNT_BITS > CfgWidth) ? COUNT_BITS : CfgWidth;

    typedef enum logic [2:0] {
        PH_SIZE     = 3'd0,
        PH_SIZE_LF  = 3'd1,
        PH_DATA     = 3'd2,
        PH_DATA_CR  = 3'd3,
        PH_DATA_LF  = 3'd4,
        PH_FINAL_CR = 3'd5,
        PH_FINAL_LF = 3'd6
    } phase_t;

    // configuration
    logic                  chunked_mode_reg;
    logic [CfgWidth-1:0]   content_length_reg;
    logic [CfgWidth-1:0]   max_body_size_reg;

    // input stage
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;

    // parser state
    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] chunk_size_reg, chunk_size_next;
    logic [COUNT_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [COUNT_BITS-1:0] body_total_reg, body_total_next;
    logic                  saw_hex_reg, saw_hex_next;
    logic                  last_chunk_reg, last_chunk_next;
    logic                  finished_reg, finished_next;
    err_t                  error_reg, error_next;

    // result stage
    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    logic                  out_body_reg, out_body_next;
    logic                  out_left_reg, out_left_next;
    logic                  out_done_reg;
    err_t                  out_err_reg;

    logic                  advance;
    hex_t                  hex;
    logic [COUNT_BITS-1:0] body_total_inc;
    logic [CmpW-1:0]       total_ext, total_inc_ext, chunk_ext, len_ext, max_ext;
    logic                  valid_c, left_c;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign hex = hex_decode(in_byte_reg);

    // saturating body count
    assign body_total_inc = (&body_total_reg) ? body_total_reg
                                              : body_total_reg + 1'b1;

    assign total_ext     = CmpW'(body_total_reg);
    assign total_inc_ext = CmpW'(body_total_inc);
    assign chunk_ext     = CmpW'(chunk_size_reg);
    assign len_ext       = CmpW'(content_length_reg);
    assign max_ext       = CmpW'(max_body_size_reg);

    always_comb begin
        phase_next      = phase_reg;
        chunk_size_next = chunk_size_reg;
        bytes_left_next = bytes_left_reg;
        body_total_next = body_total_reg;
        saw_hex_next    = saw_hex_reg;
        last_chunk_next = last_chunk_reg;
        finished_next   = finished_reg;
        error_next      = error_reg;
        valid_c         = 1'b0;
        left_c          = 1'b0;

        if (error_reg == ERR_NONE) begin
            if (chunked_mode_reg) begin
                if (finished_reg) begin
                    error_next = ERR_BAD;
                end else begin
                    unique case (phase_reg)
                        PH_SIZE: begin
                            if (in_byte_reg == CHAR_CR) begin
                                if (!saw_hex_reg) error_next = ERR_BAD;
                                else phase_next = PH_SIZE_LF;
                            end else if (!hex.ok ||
                                         (|chunk_size_reg[COUNT_BITS-1 -: 4])) begin
                                error_next = ERR_BAD;
                            end else begin
                                chunk_size_next = {chunk_size_reg[COUNT_BITS-5:0],
                                                   hex.digit};
                                saw_hex_next = 1'b1;
                            end
                        end
                        PH_SIZE_LF: begin
                            if (in_byte_reg != CHAR_LF) begin
                                error_next = ERR_BAD;
                            end else if (chunk_size_reg == '0) begin
                                last_chunk_next = 1'b1;
                                phase_next = PH_FINAL_CR;
                            end else if (chunk_ext > max_ext ||
                                         total_ext > max_ext - chunk_ext) begin
                                error_next = ERR_LARGE;
                            end else begin
                                bytes_left_next = chunk_size_reg;
                                phase_next = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            valid_c = 1'b1;
                            body_total_next = body_total_inc;
                            bytes_left_next = bytes_left_reg - 1'b1;
                            if (bytes_left_reg == COUNT_BITS'(1)) phase_next = PH_DATA_CR;
                        end
                        PH_DATA_CR: begin
                            if (in_byte_reg != CHAR_CR) error_next = ERR_BAD;
                            else phase_next = PH_DATA_LF;
                        end
                        PH_DATA_LF: begin
                            if (in_byte_reg != CHAR_LF) begin
                                error_next = ERR_BAD;
                            end else begin
                                phase_next = PH_SIZE;
                                chunk_size_next = '0;
                                saw_hex_next = 1'b0;
                            end
                        end
                        PH_FINAL_CR: begin
                            if (in_byte_reg != CHAR_CR) error_next = ERR_BAD;
                            else phase_next = PH_FINAL_LF;
                        end
                        PH_FINAL_LF: begin
                            if (in_byte_reg != CHAR_LF) error_next = ERR_BAD;
                            else finished_next = 1'b1;
                        end
                        default: error_next = ERR_BAD;
                    endcase
                end
            end else begin
                if (finished_reg) begin
                    left_c = 1'b1;
                end else if (content_length_reg == '0) begin
                    finished_next = 1'b1;
                    left_c = 1'b1;
                end else if (content_length_reg > max_body_size_reg) begin
                    error_next = ERR_LARGE;
                end else if (total_ext < len_ext) begin
                    valid_c = 1'b1;
                    body_total_next = body_total_inc;
                    if (total_inc_ext == len_ext) finished_next = 1'b1;
                end else begin
                    finished_next = 1'b1;
                    left_c = 1'b1;
                end
            end
        end

        // flags drop on the transaction that raises an error
        out_body_next = valid_c && (error_next == ERR_NONE);
        out_left_next = left_c && (error_next == ERR_NONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunked_mode_reg   <= 1'b0;
            content_length_reg <= '0;
            max_body_size_reg  <= MAX_BODY_SIZE_RESET;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            phase_reg          <= PH_SIZE;
            chunk_size_reg     <= '0;
            bytes_left_reg     <= '0;
            body_total_reg     <= '0;
            saw_hex_reg        <= 1'b0;
            last_chunk_reg     <= 1'b0;
            finished_reg       <= 1'b0;
            error_reg          <= ERR_NONE;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_CHUNKED_MODE:   chunked_mode_reg <= cfg_wdata[0];
                    REG_CONTENT_LENGTH: content_length_reg <= cfg_wdata;
                    REG_MAX_BODY_SIZE:  max_body_size_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg  <= 1'b1;
                phase_reg      <= phase_next;
                chunk_size_reg <= chunk_size_next;
                bytes_left_reg <= bytes_left_next;
                body_total_reg <= body_total_next;
                saw_hex_reg    <= saw_hex_next;
                last_chunk_reg <= last_chunk_next;
                finished_reg   <= finished_next;
                error_reg      <= error_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_byte_reg <= in_byte_reg;
            out_body_reg <= out_body_next;
            out_left_reg <= out_left_next;
            out_done_reg <= finished_next;
            out_err_reg  <= error_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_err_reg, out_done_reg, out_left_reg, out_body_reg};

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        error_reg != ERR_NONE |=> error_reg == $past(error_reg))
        else $error("held error changed without reset");

    a_body_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_body_reg |-> out_err_reg == ERR_NONE && !out_left_reg)
        else $error("body byte marked with error or leftover");

    a_left_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_left_reg |-> out_done_reg)
        else $error("leftover byte before body complete");

    a_data_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> bytes_left_reg != '0)
        else $error("chunk data phase with no bytes left");

    // the closing CRLF is only reached through a zero-size chunk
    a_final_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_FINAL_CR || phase_reg == PH_FINAL_LF) |-> last_chunk_reg)
        else $error("final CRLF phase without a last chunk");

endmodule

// ----- tb/tb_http_body_chunked_decoder.sv -----
`timescale 1ns / 1ps

module tb_http_body_chunked_decoder;
    import hbcd_pkg::*;

    localparam int CB = CountBitsDefault;
    localparam logic [CB-1:0] COUNT_ALL = '1;
    localparam int BULK_ITEMS = 1080;
    localparam int TAIL_ITEMS = 30;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [2:0] {
        AT_SIZE,
        AT_SIZE_LF,
        IN_DATA,
        AT_DATA_CR,
        AT_DATA_LF,
        AT_FINAL_CR,
        AT_FINAL_LF
    } parse_step_e;

    typedef enum int {
        END_FINAL,
        END_EMPTY_LINE,
        END_BAD_CHAR,
        END_OVERFLOW,
        END_TOO_LARGE,
        END_SPOILT_CHUNK,
        END_ZERO_LENGTH,
        END_LENGTH_OVER,
        END_LENGTH_DONE
    } ending_e;

    typedef struct packed {
        err_t err;
        logic done;
        logic leftover;
        logic body;
    } marks_t;

    typedef struct {
        logic [7:0] data;
        marks_t     marks;
    } echo_t;

    typedef enum logic {ROW_REG, ROW_BYTE} row_kind_e;

    typedef struct {
        row_kind_e              kind;
        logic [CfgIndexBits-1:0] idx;
        logic [31:0]            value;
        marks_t                 marks;
    } script_row_t;

    localparam marks_t MARKS_PARSE = '{err: ERR_NONE, done: 1'b0, leftover: 1'b0, body: 1'b0};
    localparam marks_t MARKS_BODY  = '{err: ERR_NONE, done: 1'b0, leftover: 1'b0, body: 1'b1};

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [7:0]              s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [7:0]              m_tdata;
    logic [4:0]              m_tuser;
    logic                    cfg_wr_en = 1'b0;
    logic [CfgIndexBits-1:0] cfg_index = '0;
    logic [CfgWidth-1:0]     cfg_wdata = '0;

    // decoder mirror: registers
    logic        cfg_chunked = 1'b0;
    logic [31:0] cfg_length = '0;
    logic [31:0] cfg_limit = MAX_BODY_SIZE_RESET;
    // decoder mirror: parser state
    parse_step_e   step = AT_SIZE;
    logic [CB-1:0] size_acc = '0;
    logic [CB-1:0] remaining = '0;
    logic [CB-1:0] body_count = '0;
    logic          have_digit = 1'b0;
    logic          complete = 1'b0;
    err_t          fault = ERR_NONE;

    echo_t pending_echoes[$];
    int    failures = 0;
    int    sent = 0;
    int    cycles = 0;
    int    spoil_in = -1;
    bit    steady = 1'b0;

    script_row_t opening [18] = '{
        '{ROW_REG,  REG_CHUNKED_MODE,   32'd1,          MARKS_PARSE},
        '{ROW_REG,  REG_MAX_BODY_SIZE,  32'hFFFF_FFFF,  MARKS_PARSE},
        '{ROW_BYTE, REG_CHUNKED_MODE,   32'("1"),       MARKS_PARSE},
        '{ROW_BYTE, REG_CHUNKED_MODE,   32'(CHAR_CR),   MARKS_PARSE},
        '{ROW_BYTE, REG_CHUNKED_MODE,   32'(CHAR_LF),   MARKS_PARSE},
        '{ROW_BYTE, REG_CHUNKED_MODE,   32'hFF,         MARKS_BODY},
        '{ROW_BYTE, REG_CHUNKED_MODE,   32'(CHAR_CR),   MARKS_PARSE},
        '{ROW_BYTE, REG_CHUNKED_MODE,   32'(CHAR_LF),   MARKS_PARSE},
        '{ROW_REG,  REG_CONTENT_LENGTH, 32'hFFFF_FFFF,  MARKS_PARSE},
        '{ROW_BYTE, REG_CHUNKED_MODE,   32'("0"),       MARKS_PARSE},
        '{ROW_BYTE, REG_CHUNKED_MODE,   32'("0"),       MARKS_PARSE},
        '{ROW_BYTE, REG_CHUNKED_MODE,   32'("2"),       MARKS_PARSE},
        '{ROW_BYTE, REG_CHUNKED_MODE,   32'(CHAR_CR),   MARKS_PARSE},
        '{ROW_BYTE, REG_CHUNKED_MODE,   32'(CHAR_LF),   MARKS_PARSE},
        '{ROW_BYTE, REG_CHUNKED_MODE,   32'h00,         MARKS_BODY},
        '{ROW_BYTE, REG_CHUNKED_MODE,   32'h80,         MARKS_BODY},
        '{ROW_BYTE, REG_CHUNKED_MODE,   32'(CHAR_CR),   MARKS_PARSE},
        '{ROW_BYTE, REG_CHUNKED_MODE,   32'(CHAR_LF),   MARKS_PARSE}
    };

    http_body_chunked_decoder #(
        .COUNT_BITS(CB)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0);
        if (c >= CHAR_LC_A && c <= CHAR_LC_F) return int'(c - CHAR_LC_A) + 10;
        if (c >= CHAR_UC_A && c <= CHAR_UC_F) return int'(c - CHAR_UC_A) + 10;
        return -1;
    endfunction

    // Advance the mirror by one byte and return the marks the decoder should give it.
    task automatic decode_byte(input logic [7:0] c, output echo_t res);
        logic body;
        logic left;
        int   d;
        body = 1'b0;
        left = 1'b0;
        if (fault == ERR_NONE) begin
            if (cfg_chunked) begin
                if (complete) begin
                    fault = ERR_BAD;
                end else begin
                    case (step)
                        AT_SIZE: begin
                            d = hex_nibble(c);
                            if (c == CHAR_CR) begin
                                if (!have_digit) fault = ERR_BAD;
                                else step = AT_SIZE_LF;
                            end else if (d < 0 || size_acc > (COUNT_ALL >> 4)) begin
                                fault = ERR_BAD;
                            end else begin
                                size_acc = {size_acc[CB-5:0], d[3:0]};
                                have_digit = 1'b1;
                            end
                        end
                        AT_SIZE_LF: begin
                            if (c != CHAR_LF) begin
                                fault = ERR_BAD;
                            end else if (size_acc == 0) begin
                                step = AT_FINAL_CR;
                            end else if (size_acc > cfg_limit
                                         || body_count > cfg_limit - size_acc) begin
                                fault = ERR_LARGE;
                            end else begin
                                remaining = size_acc;
                                step = IN_DATA;
                            end
                        end
                        IN_DATA: begin
                            body = 1'b1;
                            if (body_count != COUNT_ALL) body_count++;
                            remaining = remaining - 1'b1;
                            if (remaining == 0) step = AT_DATA_CR;
                        end
                        AT_DATA_CR: begin
                            if (c != CHAR_CR) fault = ERR_BAD;
                            else step = AT_DATA_LF;
                        end
                        AT_DATA_LF: begin
                            if (c != CHAR_LF) begin
                                fault = ERR_BAD;
                            end else begin
                                step = AT_SIZE;
                                size_acc = '0;
                                have_digit = 1'b0;
                            end
                        end
                        AT_FINAL_CR: begin
                            if (c != CHAR_CR) fault = ERR_BAD;
                            else step = AT_FINAL_LF;
                        end
                        AT_FINAL_LF: begin
                            if (c != CHAR_LF) fault = ERR_BAD;
                            else complete = 1'b1;
                        end
                        default: fault = ERR_BAD;
                    endcase
                end
            end else begin
                if (complete) begin
                    left = 1'b1;
                end else if (cfg_length == 0) begin
                    complete = 1'b1;
                    left = 1'b1;
                end else if (cfg_length > cfg_limit) begin
                    fault = ERR_LARGE;
                end else if (body_count < cfg_length) begin
                    body = 1'b1;
                    if (body_count != COUNT_ALL) body_count++;
                    if (body_count == cfg_length) complete = 1'b1;
                end else begin
                    complete = 1'b1;
                    left = 1'b1;
                end
            end
            if (fault != ERR_NONE) begin
                body = 1'b0;
                left = 1'b0;
            end
        end
        res.data = c;
        res.marks = '{err: fault, done: complete, leftover: left, body: body};
    endtask

    task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input marks_t typed_marks = MARKS_PARSE);
        echo_t e;
        // corrupt one byte of a chosen sequence
        if (spoil_in == 0) b = b ^ 8'($urandom_range(1, 255));
        if (spoil_in >= 0) spoil_in--;
        while (!steady && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b, e);
        if (typed) e.marks = typed_marks;
        pending_echoes.push_back(e);
        sent++;
    endtask

    task automatic write_reg(input logic [CfgIndexBits-1:0] idx, input logic [31:0] val);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_echoes.size() != 0);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_CHUNKED_MODE:   cfg_chunked = val[0];
            REG_CONTENT_LENGTH: cfg_length = val;
            REG_MAX_BODY_SIZE:  cfg_limit = val;
            default: ;
        endcase
    endtask

    task automatic send_hex(input logic [31:0] value, input int unsigned zeros);
        int unsigned digits;
        logic [3:0]  nib;
        digits = 1;
        while (digits < 8 && (value >> (4 * digits)) != 0) digits++;
        repeat (zeros) send_byte(CHAR_0);
        for (int i = int'(digits) - 1; i >= 0; i--) begin
            nib = value[4*i +: 4];
            if (nib < 4'd10) send_byte(CHAR_0 + nib);
            else send_byte(($urandom_range(0, 1) ? CHAR_UC_A : CHAR_LC_A) + nib - 8'd10);
        end
    endtask

    task automatic send_chunk(input int unsigned n, input bit detour);
        int unsigned at;
        int unsigned k;
        send_hex(n, $urandom_range(0, 2));
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        at = detour ? $urandom_range(0, n - 1) : n;
        for (int unsigned i = 0; i < n; i++) begin
            if (i == at) begin
                // drop into length mode mid-chunk without completing the body
                k = $urandom_range(1, 6);
                write_reg(REG_CHUNKED_MODE, 32'd0);
                write_reg(REG_CONTENT_LENGTH, body_count + k + $urandom_range(1, 40));
                repeat (k) send_byte(8'($urandom_range(0, 255)));
                write_reg(REG_CHUNKED_MODE, 32'd1);
            end
            send_byte(8'($urandom_range(0, 255)));
        end
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin
        echo_t  want;
        marks_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = marks_t'(m_tuser);
            if (pending_echoes.size() == 0) begin
                $display("%0t: unexpected transaction: expected none, actual byte %02h user %05b",
                         $time, m_tdata, m_tuser);
                failures++;
            end else begin
                want = pending_echoes.pop_front();
                check_field("out_byte", want.data, m_tdata);
                check_field("body_valid", want.marks.body, got.body);
                check_field("leftover", want.marks.leftover, got.leftover);
                check_field("done_res", want.marks.done, got.done);
                check_field("error_code", want.marks.err, got.err);
            end
        end
    end

    always @(posedge aclk) m_tready <= steady || $urandom_range(0, 99) >= 28;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        ending_e     ending;
        logic [7:0]  c;
        logic [31:0] big;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (opening[i]) begin
            if (opening[i].kind == ROW_REG) write_reg(opening[i].idx, opening[i].value);
            else send_byte(opening[i].value[7:0], 1'b1, opening[i].marks);
        end

        // well-formed chunks with random content; the limit is always large enough for each chunk
        while (sent < BULK_ITEMS) begin
            steady = (sent >= 400 && sent < 650);
            case ($urandom_range(0, 19))
                0: write_reg(REG_CONTENT_LENGTH, $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF);
                1: write_reg(REG_CONTENT_LENGTH, $urandom);
                2: write_reg(REG_MAX_BODY_SIZE, 32'hFFFF_FFFF);
                3: write_reg(REG_MAX_BODY_SIZE, MAX_BODY_SIZE_RESET);
                4: write_reg(REG_MAX_BODY_SIZE, body_count + 3000 + $urandom_range(0, 5000));
                default: ;
            endcase
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            if ($urandom_range(0, 14) == 0) begin
                // chunk fills the limit exactly
                write_reg(REG_MAX_BODY_SIZE, body_count + n);
                send_chunk(n, 1'b0);
                write_reg(REG_MAX_BODY_SIZE, 32'hFFFF_FFFF);
            end else begin
                send_chunk(n, $urandom_range(0, 9) == 0);
            end
        end
        steady = 1'b0;

        // a single run can only end the body one way, so pick the way at random
        ending = ending_e'($urandom_range(0, 8));
        case (ending)
            END_FINAL: begin
                if ($urandom_range(0, 1)) spoil_in = $urandom_range(1, 4);
                send_hex(32'd0, $urandom_range(0, 2));
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            END_EMPTY_LINE: send_byte(CHAR_CR);
            END_BAD_CHAR: begin
                if ($urandom_range(0, 1)) send_hex($urandom_range(1, 255), 0);
                do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0 || c == CHAR_CR);
                send_byte(c);
            end
            END_OVERFLOW: begin
                big = $urandom_range(0, 1) ? 32'h0FFF_FFFF
                                           : {4'($urandom_range(1, 15)), 28'($urandom)};
                send_hex(big, 0);
                repeat (2) send_byte(CHAR_0 + 8'($urandom_range(0, 9)));
            end
            END_TOO_LARGE: begin
                n = $urandom_range(1, 16);
                case ($urandom_range(0, 2))
                    0: write_reg(REG_MAX_BODY_SIZE, 32'd0);
                    1: begin
                        write_reg(REG_MAX_BODY_SIZE, 32'hFFFF_FFFF);
                        n = 32'hFFFF_FFFF;
                    end
                    default: write_reg(REG_MAX_BODY_SIZE, body_count + n - 1);
                endcase
                send_hex(n, 0);
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            END_SPOILT_CHUNK: begin
                spoil_in = $urandom_range(0, 10);
                send_chunk($urandom_range(1, 8), 1'b0);
            end
            END_ZERO_LENGTH: begin
                write_reg(REG_CONTENT_LENGTH, 32'd0);
                write_reg(REG_CHUNKED_MODE, 32'd0);
                repeat ($urandom_range(3, 5)) send_byte(8'($urandom_range(0, 255)));
                write_reg(REG_CHUNKED_MODE, 32'd1);
            end
            END_LENGTH_OVER: begin
                write_reg(REG_MAX_BODY_SIZE, body_count + $urandom_range(0, 1000));
                write_reg(REG_CONTENT_LENGTH, 32'hFFFF_FFFF);
                write_reg(REG_CHUNKED_MODE, 32'd0);
            end
            END_LENGTH_DONE: begin
                write_reg(REG_CONTENT_LENGTH, body_count + $urandom_range(1, 12));
                write_reg(REG_CHUNKED_MODE, 32'd0);
                repeat ($urandom_range(13, 20)) send_byte(8'($urandom_range(0, 255)));
                write_reg(REG_CHUNKED_MODE, 32'd1);
            end
            default: ;
        endcase
        spoil_in = -1;

        // random bytes after the ending, with random mode writes, are still checked against the mirror
        repeat (TAIL_ITEMS) begin
            if ($urandom_range(0, 7) == 0) write_reg(REG_CHUNKED_MODE, $urandom_range(0, 1));
            send_byte(8'($urandom_range(0, 255)));
        end

        s_tvalid <= 1'b0;
        while (pending_echoes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (failures == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
